// File: rtl/core/ifd_pkg.sv
// ----------------------------------------------------------------------------
// ifd_pkg
// Shared types, codes and the service scan order of the interrupt flag
// dispatcher.
// ----------------------------------------------------------------------------
package ifd_pkg;

    // width of the source index fields
    localparam int SRC_W     = 4;
    // width of the configuration register index
    localparam int CFG_IDX_W = 2;

    // display-side sources
    localparam logic [SRC_W-1:0] SRC_VBLANK = 4'd0;
    localparam logic [SRC_W-1:0] SRC_HBLANK = 4'd1;
    localparam logic [SRC_W-1:0] SRC_VCOUNT = 4'd2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MASTER_ENABLE  = 2'd0,
        CFG_SOURCE_ENABLE  = 2'd1,
        CFG_DISPLAY_ENABLE = 2'd2,
        CFG_HANDLER_MASK   = 2'd3
    } cfg_reg_t;

    // input command codes
    typedef enum logic [0:0] {
        CMD_RAISE   = 1'b0,
        CMD_SERVICE = 1'b1
    } cmd_code_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_EMIT
    } ctrl_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;   // capture the input word
        logic scan_clr;  // restart the scan position
        logic scan_step; // advance the scan position without a result
        logic raise_go;  // dispatch the selected source and load the result
        logic sel_scan;  // select the scan source instead of the raised one
        logic last;      // result being loaded closes the input word
    } ifd_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_service; // captured command is service-all
        logic irq_ok;     // captured source index is in range
        logic master_en;  // master enable
        logic any_elig;   // some source is pending and enabled
        logic cur_elig;   // source at the scan position is pending and enabled
        logic more_after; // another pending and enabled source remains
        logic out_last;   // held result closes its input word
    } ifd_status_t;

    // source visited at each scan position: hblank, vcount, vblank, then index order
    function automatic logic [SRC_W-1:0] scan_order(input logic [SRC_W-1:0] pos);
        logic [SRC_W-1:0] src;
        case (pos)
            4'd0:    src = SRC_HBLANK;
            4'd1:    src = SRC_VCOUNT;
            4'd2:    src = SRC_VBLANK;
            default: src = pos;
        endcase
        return src;
    endfunction

endpackage

// File: rtl/core/ifd_ctrl.sv
// ----------------------------------------------------------------------------
// ifd_ctrl
// Sequencer of the interrupt flag dispatcher: decodes each input word,
// walks the service scan and holds each result until it is taken.
// ----------------------------------------------------------------------------
module ifd_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  ifd_pkg::ifd_status_t st,
    output ifd_pkg::ifd_cmd_t    ctl
);
    import ifd_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!st.is_service)
                begin
                    state_next = st.irq_ok ? ST_EMIT : ST_IDLE;
                end
                else
                begin
                    state_next = st.master_en ? ST_SCAN : ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (!st.any_elig)
                begin
                    state_next = ST_IDLE;
                end
                else if (st.cur_elig)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    state_next = st.out_last ? ST_IDLE : ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath commands
    always_comb
    begin
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        ctl           = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                ctl.load_in = in_valid;
            end
            ST_CHECK:
            begin
                if (!st.is_service)
                begin
                    ctl.raise_go = st.irq_ok;
                    ctl.last     = 1'b1;
                end
                else
                begin
                    ctl.scan_clr = st.master_en;
                end
            end
            ST_SCAN:
            begin
                if (st.any_elig)
                begin
                    if (st.cur_elig)
                    begin
                        ctl.raise_go = 1'b1;
                        ctl.sel_scan = 1'b1;
                        ctl.last     = !st.more_after;
                    end
                    else
                    begin
                        ctl.scan_step = 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/core/ifd_datapath.sv
// ----------------------------------------------------------------------------
// ifd_datapath
// Configuration registers, pending and acknowledge flags, scan position and
// the result register of the interrupt flag dispatcher.
// ----------------------------------------------------------------------------
module ifd_datapath
#(
    parameter int SOURCE_COUNT = 14
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ifd_pkg::ifd_cmd_t                    ctl,
    output ifd_pkg::ifd_status_t                 st,
    input  logic                                 cfg_valid,
    input  logic [ifd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [SOURCE_COUNT-1:0]              cfg_data,
    input  logic                                 cmd,
    input  logic [ifd_pkg::SRC_W-1:0]            irq_id,
    output logic [ifd_pkg::SRC_W-1:0]            source_index,
    output logic                                 serviced,
    output logic                                 acknowledged,
    output logic                                 call_handler,
    output logic [SOURCE_COUNT-1:0]              pending_flags,
    output logic [SOURCE_COUNT-1:0]              ack_flags,
    output logic                                 last
);
    import ifd_pkg::*;

    localparam int POS_W = (SOURCE_COUNT > 1) ? $clog2(SOURCE_COUNT) : 1;
    localparam logic [SOURCE_COUNT-1:0] BIT0 = SOURCE_COUNT'(1);

    // configuration
    logic                    master_reg;
    logic [SOURCE_COUNT-1:0] src_en_reg;
    logic [2:0]              disp_en_reg;
    logic [SOURCE_COUNT-1:0] handler_reg;

    // flags and captured input word
    logic [SOURCE_COUNT-1:0] pending_reg;
    logic [SOURCE_COUNT-1:0] pending_next;
    logic [SOURCE_COUNT-1:0] ack_reg;
    logic [SOURCE_COUNT-1:0] ack_next;
    cmd_code_t               cmd_reg;
    logic [SRC_W-1:0]        irq_reg;
    logic [POS_W-1:0]        pos_reg;
    logic [POS_W-1:0]        pos_next;

    // result register
    logic [SRC_W-1:0]        src_out_reg;
    logic                    sv_out_reg;
    logic                    ak_out_reg;
    logic                    call_out_reg;
    logic [SOURCE_COUNT-1:0] pend_out_reg;
    logic [SOURCE_COUNT-1:0] ack_out_reg;
    logic                    last_out_reg;

    logic [SRC_W-1:0]        scan_src;
    logic [SRC_W-1:0]        sel_src;
    logic [SOURCE_COUNT-1:0] scan_bit;
    logic [SOURCE_COUNT-1:0] sel_bit;
    logic [SOURCE_COUNT-1:0] elig_vec;
    logic                    dispatch;
    logic                    disp_on;
    logic                    ak;
    logic                    call;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            master_reg  <= 1'b1;
            src_en_reg  <= '0;
            disp_en_reg <= '0;
            handler_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_MASTER_ENABLE:  master_reg  <= cfg_data[0];
                CFG_SOURCE_ENABLE:  src_en_reg  <= cfg_data;
                CFG_DISPLAY_ENABLE: disp_en_reg <= cfg_data[2:0];
                CFG_HANDLER_MASK:   handler_reg <= cfg_data;
                default:            master_reg  <= master_reg;
            endcase
        end
    end

    // source selection
    assign scan_src = scan_order(SRC_W'(pos_reg));
    assign sel_src  = ctl.sel_scan ? scan_src : irq_reg;
    assign scan_bit = BIT0 << scan_src;
    assign sel_bit  = BIT0 << sel_src;
    assign elig_vec = pending_reg & src_en_reg;

    // dispatch of one source
    always_comb
    begin
        dispatch = master_reg && (|(src_en_reg & sel_bit));
        disp_on  = |(disp_en_reg & (3'b001 << sel_src[1:0]));
        ak       = dispatch && !((sel_src <= SRC_VCOUNT) && !disp_on);
        call     = ak && (|(handler_reg & sel_bit));
        pending_next = dispatch ? (pending_reg & ~sel_bit) : (pending_reg | sel_bit);
        ack_next     = ak ? (ack_reg | sel_bit) : ack_reg;
    end

    // scan position
    always_comb
    begin
        pos_next = pos_reg;
        if (ctl.scan_clr)
        begin
            pos_next = '0;
        end
        else if (ctl.scan_step || (ctl.raise_go && ctl.sel_scan))
        begin
            pos_next = pos_reg + POS_W'(1);
        end
    end

    // flag and position registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            ack_reg     <= '0;
            pos_reg     <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            if (ctl.raise_go)
            begin
                pending_reg <= pending_next;
                ack_reg     <= ack_next;
            end
        end
    end

    // captured input word
    always_ff @(posedge clk)
    begin
        if (ctl.load_in)
        begin
            cmd_reg <= cmd_code_t'(cmd);
            irq_reg <= irq_id;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_out_reg  <= '0;
            sv_out_reg   <= 1'b0;
            ak_out_reg   <= 1'b0;
            call_out_reg <= 1'b0;
            pend_out_reg <= '0;
            ack_out_reg  <= '0;
            last_out_reg <= 1'b0;
        end
        else if (ctl.raise_go)
        begin
            src_out_reg  <= sel_src;
            sv_out_reg   <= dispatch;
            ak_out_reg   <= ak;
            call_out_reg <= call;
            pend_out_reg <= pending_next;
            ack_out_reg  <= ack_next;
            last_out_reg <= ctl.last;
        end
    end

    // status to the controller
    always_comb
    begin
        st.is_service = (cmd_reg == CMD_SERVICE);
        st.irq_ok     = ({1'b0, irq_reg} < (SRC_W + 1)'(SOURCE_COUNT));
        st.master_en  = master_reg;
        st.any_elig   = |elig_vec;
        st.cur_elig   = |(elig_vec & scan_bit);
        st.more_after = |(elig_vec & ~scan_bit);
        st.out_last   = last_out_reg;
    end

    assign source_index  = src_out_reg;
    assign serviced      = sv_out_reg;
    assign acknowledged  = ak_out_reg;
    assign call_handler  = call_out_reg;
    assign pending_flags = pend_out_reg;
    assign ack_flags     = ack_out_reg;
    assign last          = last_out_reg;

    // acknowledge flags are only ever set
    a_ack_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (($past(ack_reg) & ~ack_reg) == '0))
        else $error("acknowledge flag cleared");

    // a handler call needs an acknowledge
    a_call_needs_ack: assert property (@(posedge clk) disable iff (!rst_n)
        call_out_reg |-> ak_out_reg)
        else $error("handler call without acknowledge");

    // an acknowledge needs a dispatch
    a_ack_needs_service: assert property (@(posedge clk) disable iff (!rst_n)
        ak_out_reg |-> sv_out_reg)
        else $error("acknowledge without dispatch");

    // a dispatched source leaves its pending bit clear
    a_serviced_clear: assert property (@(posedge clk) disable iff (!rst_n)
        sv_out_reg |-> ((pend_out_reg & (BIT0 << src_out_reg)) == '0))
        else $error("dispatched source still pending");

endmodule

// File: rtl/core/interrupt_flag_dispatcher_core.sv
// ----------------------------------------------------------------------------
// interrupt_flag_dispatcher_core
// Interrupt flag dispatcher with pending and acknowledge flags, enables
// and a service-all scan.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one word: cmd raise with
//   irq_id, or cmd service-all. Results leave on the output channel
//   (out_valid/out_ready), one word per dispatched or raised source, with
//   last marking the final word of an input.
//   Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are
//   always ready and belong to idle periods.
//   A raise is checked and its result is registered and held on the output;
//   an out of range raise gives nothing and the block is ready again.
//   Service-all walks the scan positions one per cycle while no result is
//   held (hblank, vcount, vblank, then index order) and stops once nothing
//   pending and enabled remains.
//   The next input word is taken once the last result has been taken.
//   When the receiver stalls, the held result and the whole scan wait.
//   Reset: master enable set, all masks, pending and acknowledge flags clear.
// ----------------------------------------------------------------------------
module interrupt_flag_dispatcher_core
#(
    parameter int SOURCE_COUNT = 14
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          cmd,
    input  logic [ifd_pkg::SRC_W-1:0]     irq_id,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ifd_pkg::SRC_W-1:0]     source_index,
    output logic                          serviced,
    output logic                          acknowledged,
    output logic                          call_handler,
    output logic [SOURCE_COUNT-1:0]       pending_flags,
    output logic [SOURCE_COUNT-1:0]       ack_flags,
    output logic                          last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ifd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [SOURCE_COUNT-1:0]       cfg_data
);
    import ifd_pkg::*;

    ifd_cmd_t    ctl;
    ifd_status_t st;

    // configuration is taken at any time
    assign cfg_ready = 1'b1;

    // sequencer
    ifd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .ctl       (ctl)
    );

    // flags, configuration and result register
    ifd_datapath #(
        .SOURCE_COUNT (SOURCE_COUNT)
    ) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .st            (st),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .irq_id        (irq_id),
        .source_index  (source_index),
        .serviced      (serviced),
        .acknowledged  (acknowledged),
        .call_handler  (call_handler),
        .pending_flags (pending_flags),
        .ack_flags     (ack_flags),
        .last          (last)
    );

endmodule
